@@ hw/rtl/dwc_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, codes and control types for the deque with cursor.
package dwc_pkg;

  // Ring depth; must be a power of two (ring positions wrap by truncation)
  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = IDX_W + 1;

  localparam int DATA_W  = 32;
  localparam int FUNC_W  = 3;
  localparam int STAT_W  = 2;
  localparam int RES_W   = STAT_W + 4 * DATA_W + 1 + CNT_W;
  localparam int OUT_W   = ((RES_W + 7) / 8) * 8;

  // Command codes
  localparam logic [FUNC_W-1:0] FN_PUSH_L = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_R = 3'd1;
  localparam logic [FUNC_W-1:0] FN_POP_L  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_POP_R  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CUR_L  = 3'd4;
  localparam logic [FUNC_W-1:0] FN_CUR_R  = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SET    = 3'd6;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_AT_END = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // capture an accepted transaction
    logic exec;     // update pointers and write the ring
    logic rd_lr;    // read both end entries
    logic rd_cur;   // capture end values, read cursor entry
    logic publish;  // load the output register
  } dwc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free; // output register can take a result this cycle
  } dwc_stat_t;

endpackage

@@ hw/rtl/dwc_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer that steps each command through execute, read and publish.
module dwc_ctrl
  import dwc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  dwc_stat_t stat,
  output dwc_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_RD_LR  = 5'b00100,
    S_RD_CUR = 5'b01000,
    S_FIN    = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  // Next state and command decode
  always_comb begin
    state_next  = state;
    cmd         = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_RD_LR;
      end
      S_RD_LR: begin
        cmd.rd_lr  = 1'b1;
        state_next = S_RD_CUR;
      end
      S_RD_CUR: begin
        cmd.rd_cur = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        // wait here while the previous result is still held
        if (stat.out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ hw/rtl/dwc_datapath.sv @@
`timescale 1ns / 1ps
// Ring storage, end and cursor pointers, and the result register.
module dwc_datapath
  import dwc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  dwc_cmd_t           cmd,
  output dwc_stat_t          stat,
  input  logic [FUNC_W-1:0]  in_func,
  input  logic [DATA_W-1:0]  in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [OUT_W-1:0]   out_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Captured transaction
  logic [FUNC_W-1:0] func;
  logic [DATA_W-1:0] value;

  // Pointer state
  logic [IDX_W-1:0] left_index;
  logic [IDX_W-1:0] cursor_index;
  logic [CNT_W-1:0] entry_count;
  logic [IDX_W-1:0] left_index_next;
  logic [IDX_W-1:0] cursor_index_next;
  logic [CNT_W-1:0] entry_count_next;

  // Per-command results
  logic [STAT_W-1:0] status;
  logic [DATA_W-1:0] popped;
  logic [STAT_W-1:0] status_next;
  logic [DATA_W-1:0] popped_next;

  // Read data and end values of the current contents
  logic [DATA_W-1:0] rd_a;
  logic [DATA_W-1:0] rd_b;
  logic [DATA_W-1:0] left_val;
  logic [DATA_W-1:0] right_val;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [IDX_W-1:0]  right_pos;
  logic              empty;
  logic              full;
  logic              cnt_valid;

  assign empty     = (entry_count == '0);
  assign full      = (entry_count == CNT_W'(DEPTH));
  assign right_pos = left_index + entry_count[IDX_W-1:0] - IDX_W'(1);
  assign cnt_valid = ~empty;

  // Command execution
  always_comb begin
    left_index_next   = left_index;
    cursor_index_next = cursor_index;
    entry_count_next  = entry_count;
    status_next       = STAT_OK;
    popped_next       = '0;
    wr_en             = 1'b0;
    wr_addr           = left_index;
    case (func)
      FN_PUSH_L, FN_PUSH_R: begin
        if (full) begin
          status_next = STAT_FULL;
        end else if (empty) begin
          wr_en             = 1'b1;
          wr_addr           = left_index;
          cursor_index_next = left_index;
          entry_count_next  = CNT_W'(1);
        end else if (func == FN_PUSH_L) begin
          wr_en            = 1'b1;
          wr_addr          = left_index - IDX_W'(1);
          left_index_next  = left_index - IDX_W'(1);
          entry_count_next = entry_count + CNT_W'(1);
        end else begin
          wr_en            = 1'b1;
          wr_addr          = left_index + entry_count[IDX_W-1:0];
          entry_count_next = entry_count + CNT_W'(1);
        end
      end
      FN_POP_L: begin
        if (empty) begin
          status_next = STAT_EMPTY;
        end else begin
          popped_next = left_val;
          if (cursor_index == left_index) begin
            cursor_index_next = cursor_index + IDX_W'(1);
          end
          entry_count_next = entry_count - CNT_W'(1);
          if (entry_count != CNT_W'(1)) begin
            left_index_next = left_index + IDX_W'(1);
          end
        end
      end
      FN_POP_R: begin
        if (empty) begin
          status_next = STAT_EMPTY;
        end else begin
          popped_next = right_val;
          if (cursor_index == right_pos) begin
            cursor_index_next = cursor_index - IDX_W'(1);
          end
          entry_count_next = entry_count - CNT_W'(1);
        end
      end
      FN_CUR_L: begin
        if (empty) begin
          status_next = STAT_EMPTY;
        end else if (cursor_index == left_index) begin
          status_next = STAT_AT_END;
        end else begin
          cursor_index_next = cursor_index - IDX_W'(1);
        end
      end
      FN_CUR_R: begin
        if (empty) begin
          status_next = STAT_EMPTY;
        end else if (cursor_index == right_pos) begin
          status_next = STAT_AT_END;
        end else begin
          cursor_index_next = cursor_index + IDX_W'(1);
        end
      end
      FN_SET: begin
        if (empty) begin
          status_next = STAT_EMPTY;
        end else begin
          wr_en   = 1'b1;
          wr_addr = cursor_index;
        end
      end
      default: begin
      end
    endcase
  end

  // Transaction capture and execute-stage registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func  <= in_func;
      value <= in_value;
    end
    if (cmd.exec) begin
      status <= status_next;
      popped <= popped_next;
    end
    if (cmd.rd_cur) begin
      left_val  <= rd_a;
      right_val <= rd_b;
    end
  end

  // Pointer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      left_index   <= '0;
      cursor_index <= '0;
      entry_count  <= '0;
    end else if (cmd.exec) begin
      left_index   <= left_index_next;
      cursor_index <= cursor_index_next;
      entry_count  <= entry_count_next;
    end
  end

  // Ring memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wr_addr] <= value;
    end
    if (cmd.rd_lr) begin
      rd_a <= mem[left_index];
      rd_b <= mem[right_pos];
    end else if (cmd.rd_cur) begin
      rd_a <= mem[cursor_index];
    end
  end

  // Output register
  assign stat.out_free = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_data <= {(OUT_W - RES_W)'(0),
                   entry_count,
                   cnt_valid,
                   cnt_valid ? rd_a : '0,
                   cnt_valid ? right_val : '0,
                   cnt_valid ? left_val : '0,
                   popped,
                   status};
    end
  end

endmodule

@@ hw/rtl/deque_with_cursor.sv @@
`timescale 1ns / 1ps
// Each input transaction steps through execute, two ring reads (both end entries,
// then the cursor entry) through the read ports, then the output register.
// The sequencer handles one command at a time and takes the next once the
// result sits in the output register. A result still held by the receiver
// delays the publish step, and so the input.
// Reset (rst, synchronous): deque empty, pointers zero, no result pending;
// ring contents are not cleared.
module deque_with_cursor
  import dwc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,  // [31:0] value
  input  logic [FUNC_W-1:0] s_axis_tuser,  // [2:0] func
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // [1:0] status, [33:2] popped_value, [65:34] left_value, [97:66] right_value,
  // [129:98] cursor_value, [130] cursor_valid, [137:131] count, rest zero
  output logic [OUT_W-1:0]  m_axis_tdata
);

  dwc_cmd_t  cmd;
  dwc_stat_t stat;

  // Sequencer
  dwc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Ring, pointers and result register
  dwc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_func   (s_axis_tuser),
    .in_value  (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule
